// ----- rtl/bkt_pkg.sv -----
// Shared types and constants for the button to key injection tracker.
// Used by bkt_ctrl, bkt_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package bkt_pkg;

  // Fixed field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned BtnW    = 5;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned MouseW  = 3;
  localparam int unsigned CntW    = 3;
  localparam int unsigned KindW   = 3;
  localparam int unsigned StepW   = 2;
  localparam int unsigned SubFields = 4;

  localparam logic signed [StepW-1:0] WheelUp   = 2'sd1;
  localparam logic signed [StepW-1:0] WheelDown = -2'sd1;

  // Input command codes
  typedef enum logic [CmdW-1:0] {
    CMD_KEY         = 3'd0,
    CMD_CLICK       = 3'd1,
    CMD_TOGGLE      = 3'd2,
    CMD_WHEEL_UP    = 3'd3,
    CMD_WHEEL_DOWN  = 3'd4,
    CMD_NOP         = 3'd5,
    CMD_RELEASE_ALL = 3'd6
  } cmd_e;

  // Output event kinds
  typedef enum logic [KindW-1:0] {
    EV_KEY_DOWN    = 3'd0,
    EV_KEY_UP      = 3'd1,
    EV_MOUSE_DOWN  = 3'd2,
    EV_MOUSE_UP    = 3'd3,
    EV_WHEEL       = 3'd4,
    EV_NOTICE      = 3'd5,
    EV_RELEASE_ALL = 3'd6
  } ev_e;

  // Source that fills the output register
  typedef enum logic [3:0] {
    SRC_KEY_MAIN,
    SRC_KEY_SUB,
    SRC_CLICK,
    SRC_TOG_MOUSE,
    SRC_TOG_NOTICE,
    SRC_WHEEL,
    SRC_REL_SUB,
    SRC_REL_MAIN,
    SRC_REL_CLICK,
    SRC_RA_HEAD,
    SRC_RA_NOTICE
  } src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_KEY_MAIN,
    S_KEY_SUB,
    S_CLICK,
    S_TOG_MOUSE,
    S_TOG_NOTICE,
    S_WHEEL,
    S_REL_RD,
    S_REL_SUB,
    S_REL_MAIN,
    S_REL_CLICK,
    S_RA_HEAD,
    S_RA_WALK,
    S_RA_CLEAR
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the input transaction
    logic emit;       // load the output register
    src_e src;
    logic last;
    logic set_main;   // record main key as held
    logic sub_next;   // store the next sub key, consume it
    logic set_click;
    logic tog_flip;
    logic rel_load;   // load release counter from the held count
    logic rel_read;   // read the next held sub key
    logic clr_main;
    logic clr_click;
    logic walk_clr;   // drop the latch at the walk index
    logic walk_inc;
    logic clear_all;
  } dp_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic           out_free;
    logic           in_range;
    logic [CmdW-1:0] cmd;
    logic           pressed;
    logic           main_vld;
    logic           click_vld;
    logic           tog_vld;
    logic           tog_any;
    logic           tog_rest;
    logic           sub_any;
    logic           sub_rest;
    logic           cnt_nz;
    logic           rel_nz;
  } dp_sts_t;

endpackage

// ----- rtl/button_to_key_injection_tracker.sv -----
// Top level of the button to key injection tracker.
// Depends on bkt_pkg, bkt_ctrl and bkt_dp.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o    | command, button, pressed, main_key,
//           |                            | mouse_button, sub_count, sub_key_0..3
//   out     | out_valid_o / out_stall_i  | event_kind, key_code, mouse_code,
//           |                            | wheel_step, notice_button, latch_on, last
//
// A transaction is captured and decoded, then its press events go out one by one; a
// release sends each held sub key after a registered memory read, then the main key and
// click stages. Release all walks the latches one button a cycle, waiting at a latched
// button while the output is stalled, then clears them. The input stalls until the
// controller is idle again; a stalled output holds its register and the controller waits.
// Reset clears all records at once; the sub key memory holds no reset value.
`timescale 1ns / 1ps

module button_to_key_injection_tracker
  import bkt_pkg::*;
#(
  parameter int NUM_BUTTONS = 32,
  parameter int MAX_SUBS    = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CmdW-1:0]          command_i,
  input  logic [BtnW-1:0]          button_i,
  input  logic                     pressed_i,
  input  logic [KeyW-1:0]          main_key_i,
  input  logic [MouseW-1:0]        mouse_button_i,
  input  logic [CntW-1:0]          sub_count_i,
  input  logic [KeyW-1:0]          sub_key_0_i,
  input  logic [KeyW-1:0]          sub_key_1_i,
  input  logic [KeyW-1:0]          sub_key_2_i,
  input  logic [KeyW-1:0]          sub_key_3_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [KindW-1:0]         event_kind_o,
  output logic [KeyW-1:0]          key_code_o,
  output logic [MouseW-1:0]        mouse_code_o,
  output logic signed [StepW-1:0]  wheel_step_o,
  output logic [BtnW-1:0]          notice_button_o,
  output logic                     latch_on_o,
  output logic                     last_o
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  // Sequencer
  bkt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Records, memory and output register
  bkt_dp #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .MAX_SUBS    (MAX_SUBS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .command_i       (command_i),
    .button_i        (button_i),
    .pressed_i       (pressed_i),
    .main_key_i      (main_key_i),
    .mouse_button_i  (mouse_button_i),
    .sub_count_i     (sub_count_i),
    .sub_key_0_i     (sub_key_0_i),
    .sub_key_1_i     (sub_key_1_i),
    .sub_key_2_i     (sub_key_2_i),
    .sub_key_3_i     (sub_key_3_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .event_kind_o    (event_kind_o),
    .key_code_o      (key_code_o),
    .mouse_code_o    (mouse_code_o),
    .wheel_step_o    (wheel_step_o),
    .notice_button_o (notice_button_o),
    .latch_on_o      (latch_on_o),
    .last_o          (last_o),
    .ctl_i           (ctl),
    .sts_o           (sts)
  );

endmodule

// ----- rtl/bkt_dp.sv -----
// Datapath: input holding registers, per-button records, sub key memory and output register.
// Depends on bkt_pkg; driven by bkt_ctrl through dp_ctl_t.
`timescale 1ns / 1ps

module bkt_dp
  import bkt_pkg::*;
#(
  parameter int NUM_BUTTONS = 32,
  parameter int MAX_SUBS    = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CmdW-1:0]          command_i,
  input  logic [BtnW-1:0]          button_i,
  input  logic                     pressed_i,
  input  logic [KeyW-1:0]          main_key_i,
  input  logic [MouseW-1:0]        mouse_button_i,
  input  logic [CntW-1:0]          sub_count_i,
  input  logic [KeyW-1:0]          sub_key_0_i,
  input  logic [KeyW-1:0]          sub_key_1_i,
  input  logic [KeyW-1:0]          sub_key_2_i,
  input  logic [KeyW-1:0]          sub_key_3_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic [KindW-1:0]         event_kind_o,
  output logic [KeyW-1:0]          key_code_o,
  output logic [MouseW-1:0]        mouse_code_o,
  output logic signed [StepW-1:0]  wheel_step_o,
  output logic [BtnW-1:0]          notice_button_o,
  output logic                     latch_on_o,
  output logic                     last_o,
  input  dp_ctl_t                  ctl_i,
  output dp_sts_t                  sts_o
);

  localparam int NB     = NUM_BUTTONS;
  localparam int IdxW   = (NB > 1) ? $clog2(NB) : 1;
  localparam int Depth  = NB * MAX_SUBS;
  localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SubLim = (MAX_SUBS < SubFields) ? MAX_SUBS : SubFields;

  // Input holding registers
  logic [CmdW-1:0]   cmd_q;
  logic [BtnW-1:0]   btn_q;
  logic              pressed_q;
  logic [KeyW-1:0]   mk_q;
  logic [MouseW-1:0] mb_q;
  logic [KeyW-1:0]   subs_q [SubFields];
  logic [SubFields-1:0] mask_q, mask_d;

  // Per-button records
  logic [NB-1:0]     main_vld_q, click_vld_q, tog_vld_q;
  logic [KeyW-1:0]   main_held_q [NB];
  logic [MouseW-1:0] click_held_q [NB];
  logic [MouseW-1:0] tog_held_q [NB];
  logic [CntW-1:0]   sub_cnt_q [NB];

  // Sub key memory
  logic [KeyW-1:0]   sub_mem [Depth];
  logic [KeyW-1:0]   mem_rdata_q;

  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   rel_q;
  logic [IdxW-1:0]   idx_q;

  logic              out_valid_q;
  logic [KindW-1:0]  kind_q, kind_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [MouseW-1:0] mouse_q, mouse_d;
  logic signed [StepW-1:0] step_q, step_d;
  logic [BtnW-1:0]   nbtn_q, nbtn_d;
  logic              latch_q, latch_d;
  logic              last_q;

  logic              is_ra;
  logic [IdxW-1:0]   addr;
  logic [NB-1:0]     addr_hot;
  logic [AW-1:0]     base;
  logic [1:0]        sel;
  logic [SubFields-1:0] mask_rest;
  logic [KeyW-1:0]   sub_in [SubFields];

  // Record address: walk index during release all, else the button
  assign is_ra    = (cmd_q == CMD_RELEASE_ALL);
  assign addr     = is_ra ? idx_q : IdxW'(btn_q);
  assign addr_hot = {{(NB-1){1'b0}}, 1'b1} << addr;
  assign base     = AW'(addr) * AW'(MAX_SUBS);

  // Pick the lowest pending sub key
  always_comb begin
    sel = 2'd0;
    for (int i = SubFields - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = 2'(i);
    end
  end
  assign mask_rest = mask_q & (mask_q - SubFields'(1));

  // Mark sub keys to send: within the count limit and not equal to the main key
  assign sub_in[0] = sub_key_0_i;
  assign sub_in[1] = sub_key_1_i;
  assign sub_in[2] = sub_key_2_i;
  assign sub_in[3] = sub_key_3_i;
  always_comb begin
    for (int i = 0; i < SubFields; i++) begin
      mask_d[i] = (32'(sub_count_i) > i) && (i < SubLim) && (sub_in[i] != main_key_i);
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q     <= command_i;
      btn_q     <= button_i;
      pressed_q <= pressed_i;
      mk_q      <= main_key_i;
      mb_q      <= mouse_button_i;
      for (int i = 0; i < SubFields; i++) subs_q[i] <= sub_in[i];
    end
  end

  // Sequencing counters and the pending sub mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      cnt_q  <= '0;
      rel_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (ctl_i.capture) begin
        mask_q <= mask_d;
        cnt_q  <= '0;
        idx_q  <= '0;
      end
      if (ctl_i.sub_next) begin
        mask_q <= mask_rest;
        cnt_q  <= cnt_q + CntW'(1);
      end
      if (ctl_i.rel_load) rel_q <= sub_cnt_q[addr];
      if (ctl_i.rel_read) rel_q <= rel_q - CntW'(1);
      if (ctl_i.walk_inc) idx_q <= idx_q + IdxW'(1);
    end
  end

  // Record valid bits and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q  <= '0;
      click_vld_q <= '0;
      tog_vld_q   <= '0;
      for (int i = 0; i < NB; i++) sub_cnt_q[i] <= '0;
    end else if (ctl_i.clear_all) begin
      main_vld_q  <= '0;
      click_vld_q <= '0;
      tog_vld_q   <= '0;
      for (int i = 0; i < NB; i++) sub_cnt_q[i] <= '0;
    end else begin
      if (ctl_i.set_main)  main_vld_q  <= main_vld_q | addr_hot;
      if (ctl_i.clr_main)  main_vld_q  <= main_vld_q & ~addr_hot;
      if (ctl_i.set_click) click_vld_q <= click_vld_q | addr_hot;
      if (ctl_i.clr_click) click_vld_q <= click_vld_q & ~addr_hot;
      if (ctl_i.tog_flip)  tog_vld_q   <= tog_vld_q ^ addr_hot;
      if (ctl_i.walk_clr)  tog_vld_q   <= tog_vld_q & ~addr_hot;
      if (ctl_i.set_main)  sub_cnt_q[addr] <= '0;
      if (ctl_i.sub_next)  sub_cnt_q[addr] <= cnt_q + CntW'(1);
      if (ctl_i.rel_load)  sub_cnt_q[addr] <= '0;
    end
  end

  // Record payloads
  always_ff @(posedge clk_i) begin
    if (ctl_i.set_main)  main_held_q[addr]  <= mk_q;
    if (ctl_i.set_click) click_held_q[addr] <= mb_q;
    if (ctl_i.tog_flip && !tog_vld_q[addr]) tog_held_q[addr] <= mb_q;
  end

  // Sub key memory: write on press, registered read on release
  always_ff @(posedge clk_i) begin
    if (ctl_i.sub_next) sub_mem[base + AW'(cnt_q)] <= subs_q[sel];
    if (ctl_i.rel_read) mem_rdata_q <= sub_mem[base + AW'(rel_q - CntW'(1))];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Select the payload of the next output transaction
  always_comb begin
    kind_d  = EV_KEY_DOWN;
    key_d   = '0;
    mouse_d = '0;
    step_d  = '0;
    nbtn_d  = '0;
    latch_d = 1'b0;
    case (ctl_i.src)
      SRC_KEY_MAIN: key_d = mk_q;
      SRC_KEY_SUB:  key_d = subs_q[sel];
      SRC_CLICK: begin
        kind_d  = EV_MOUSE_DOWN;
        mouse_d = mb_q;
      end
      SRC_TOG_MOUSE: begin
        kind_d  = tog_vld_q[addr] ? EV_MOUSE_UP : EV_MOUSE_DOWN;
        mouse_d = mb_q;
      end
      SRC_TOG_NOTICE: begin
        kind_d  = EV_NOTICE;
        mouse_d = mb_q;
        nbtn_d  = btn_q;
        latch_d = !tog_vld_q[addr];
      end
      SRC_WHEEL: begin
        kind_d = EV_WHEEL;
        step_d = (cmd_q == CMD_WHEEL_UP) ? WheelUp : WheelDown;
      end
      SRC_REL_SUB: begin
        kind_d = EV_KEY_UP;
        key_d  = mem_rdata_q;
      end
      SRC_REL_MAIN: begin
        kind_d = EV_KEY_UP;
        key_d  = main_held_q[addr];
      end
      SRC_REL_CLICK: begin
        kind_d  = EV_MOUSE_UP;
        mouse_d = click_held_q[addr];
      end
      SRC_RA_HEAD: kind_d = EV_RELEASE_ALL;
      SRC_RA_NOTICE: begin
        kind_d  = EV_NOTICE;
        mouse_d = tog_held_q[addr];
        nbtn_d  = BtnW'(idx_q);
      end
      default: kind_d = EV_KEY_DOWN;
    endcase
  end

  // Load the output payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      kind_q  <= kind_d;
      key_q   <= key_d;
      mouse_q <= mouse_d;
      step_q  <= step_d;
      nbtn_q  <= nbtn_d;
      latch_q <= latch_d;
      last_q  <= ctl_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign key_code_o      = key_q;
  assign mouse_code_o    = mouse_q;
  assign wheel_step_o    = step_q;
  assign notice_button_o = nbtn_q;
  assign latch_on_o      = latch_q;
  assign last_o          = last_q;

  // Status back to the controller
  always_comb begin
    sts_o.out_free  = !out_valid_q || !out_stall_i;
    sts_o.in_range  = (32'(btn_q) < NB);
    sts_o.cmd       = cmd_q;
    sts_o.pressed   = pressed_q;
    sts_o.main_vld  = main_vld_q[addr];
    sts_o.click_vld = click_vld_q[addr];
    sts_o.tog_vld   = tog_vld_q[addr];
    sts_o.tog_any   = |tog_vld_q;
    sts_o.tog_rest  = |(tog_vld_q & ~addr_hot);
    sts_o.sub_any   = |mask_q;
    sts_o.sub_rest  = |mask_rest;
    sts_o.cnt_nz    = (sub_cnt_q[addr] != '0);
    sts_o.rel_nz    = (rel_q != '0);
  end

endmodule

// ----- rtl/bkt_ctrl.sv -----
// Controller: sequences the result events of one input transaction.
// Depends on bkt_pkg; commands bkt_dp through dp_ctl_t, reads dp_sts_t.
`timescale 1ns / 1ps

module bkt_ctrl
  import bkt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_ctl_t ctl_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.src = SRC_KEY_MAIN;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.cmd == CMD_RELEASE_ALL) begin
          state_d = S_RA_HEAD;
        end else if (!sts_i.in_range) begin
          state_d = S_IDLE;
        end else if (!sts_i.pressed) begin
          ctl_o.rel_load = 1'b1;
          state_d = sts_i.cnt_nz ? S_REL_RD : S_REL_MAIN;
        end else begin
          case (sts_i.cmd) inside
            CMD_KEY:    state_d = sts_i.main_vld ? S_IDLE : S_KEY_MAIN;
            CMD_CLICK:  state_d = sts_i.click_vld ? S_IDLE : S_CLICK;
            CMD_TOGGLE: state_d = S_TOG_MOUSE;
            CMD_WHEEL_UP, CMD_WHEEL_DOWN: state_d = S_WHEEL;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_KEY_MAIN: begin
        if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.src      = SRC_KEY_MAIN;
          ctl_o.last     = !sts_i.sub_any;
          ctl_o.set_main = 1'b1;
          state_d = sts_i.sub_any ? S_KEY_SUB : S_IDLE;
        end
      end
      S_KEY_SUB: begin
        if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.src      = SRC_KEY_SUB;
          ctl_o.last     = !sts_i.sub_rest;
          ctl_o.sub_next = 1'b1;
          state_d = sts_i.sub_rest ? S_KEY_SUB : S_IDLE;
        end
      end
      S_CLICK: begin
        if (sts_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.src       = SRC_CLICK;
          ctl_o.last      = 1'b1;
          ctl_o.set_click = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TOG_MOUSE: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.src  = SRC_TOG_MOUSE;
          state_d = S_TOG_NOTICE;
        end
      end
      S_TOG_NOTICE: begin
        if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.src      = SRC_TOG_NOTICE;
          ctl_o.last     = 1'b1;
          ctl_o.tog_flip = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WHEEL: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.src  = SRC_WHEEL;
          ctl_o.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_REL_RD: begin
        ctl_o.rel_read = 1'b1;
        state_d = S_REL_SUB;
      end
      S_REL_SUB: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.src  = SRC_REL_SUB;
          ctl_o.last = !sts_i.rel_nz && !sts_i.main_vld && !sts_i.click_vld;
          state_d = sts_i.rel_nz ? S_REL_RD : S_REL_MAIN;
        end
      end
      S_REL_MAIN: begin
        if (!sts_i.main_vld) begin
          state_d = S_REL_CLICK;
        end else if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.src      = SRC_REL_MAIN;
          ctl_o.last     = !sts_i.click_vld;
          ctl_o.clr_main = 1'b1;
          state_d = S_REL_CLICK;
        end
      end
      S_REL_CLICK: begin
        if (!sts_i.click_vld) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.src       = SRC_REL_CLICK;
          ctl_o.last      = 1'b1;
          ctl_o.clr_click = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RA_HEAD: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.src  = SRC_RA_HEAD;
          ctl_o.last = !sts_i.tog_any;
          state_d = sts_i.tog_any ? S_RA_WALK : S_RA_CLEAR;
        end
      end
      S_RA_WALK: begin
        // Skip unlatched buttons; send a cleared notice for each latched one
        if (!sts_i.tog_vld) begin
          ctl_o.walk_inc = 1'b1;
        end else if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.src      = SRC_RA_NOTICE;
          ctl_o.last     = !sts_i.tog_rest;
          ctl_o.walk_clr = 1'b1;
          ctl_o.walk_inc = 1'b1;
          state_d = sts_i.tog_rest ? S_RA_WALK : S_RA_CLEAR;
        end
      end
      S_RA_CLEAR: begin
        ctl_o.clear_all = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for button_to_key_injection_tracker.
// Predicts the key, mouse, wheel, notice and release-all events of each accepted button
// transaction and checks all outputs in order. Depends on bkt_pkg and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import bkt_pkg::*;

  localparam int NumButtons = 32;
  localparam int MaxSubs    = 4;
  localparam int IdleLimit  = 4000;
  localparam int SettleCycles = NumButtons + 8;
  localparam int ErrorReportMax = 10;
  localparam int RandomItems = 354;
  localparam logic [CmdW-1:0] CmdUnused = 3'd7;

  // One controller button transaction
  typedef struct packed {
    logic [CmdW-1:0]                 cmd;
    logic [BtnW-1:0]                 btn;
    logic                            pressed;
    logic [KeyW-1:0]                 main_key;
    logic [MouseW-1:0]               mouse;
    logic [CntW-1:0]                 sub_cnt;
    logic [SubFields-1:0][KeyW-1:0]  subs;
  } btn_event_t;

  // One injected key or mouse event
  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic [KeyW-1:0]          key;
    logic [MouseW-1:0]        mouse;
    logic signed [StepW-1:0]  wheel;
    logic [BtnW-1:0]          nbtn;
    logic                     latch;
    logic                     last;
  } inject_ev_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  logic [CmdW-1:0]   cmd;
  logic [BtnW-1:0]   button;
  logic              pressed;
  logic [KeyW-1:0]   main_key;
  logic [MouseW-1:0] mouse_button;
  logic [CntW-1:0]   sub_count;
  logic [KeyW-1:0]   sub_key_0;
  logic [KeyW-1:0]   sub_key_1;
  logic [KeyW-1:0]   sub_key_2;
  logic [KeyW-1:0]   sub_key_3;
  logic              out_valid;
  logic              out_stall;
  logic [KindW-1:0]  event_kind;
  logic [KeyW-1:0]   key_code;
  logic [MouseW-1:0] mouse_code;
  logic signed [StepW-1:0] wheel_step;
  logic [BtnW-1:0]   notice_button;
  logic              latch_on;
  logic              last_flag;

  button_to_key_injection_tracker #(
    .NUM_BUTTONS(NumButtons),
    .MAX_SUBS   (MaxSubs)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (cmd),
    .button_i       (button),
    .pressed_i      (pressed),
    .main_key_i     (main_key),
    .mouse_button_i (mouse_button),
    .sub_count_i    (sub_count),
    .sub_key_0_i    (sub_key_0),
    .sub_key_1_i    (sub_key_1),
    .sub_key_2_i    (sub_key_2),
    .sub_key_3_i    (sub_key_3),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_kind_o   (event_kind),
    .key_code_o     (key_code),
    .mouse_code_o   (mouse_code),
    .wheel_step_o   (wheel_step),
    .notice_button_o(notice_button),
    .latch_on_o     (latch_on),
    .last_o         (last_flag)
  );

  // Tracker records as the predictor sees them
  logic            main_vld  [NumButtons];
  logic [KeyW-1:0] main_code [NumButtons];
  logic [KeyW-1:0] sub_codes [NumButtons][MaxSubs];
  int unsigned     sub_held  [NumButtons];
  logic            click_vld [NumButtons];
  logic [MouseW-1:0] click_mb [NumButtons];
  logic            latch_vld [NumButtons];
  logic [MouseW-1:0] latch_mb [NumButtons];

  inject_ev_t  expected_events[$];
  int unsigned error_count;
  int unsigned sent_items;
  int unsigned burst_left;
  bit          gaps_on;
  logic [BtnW-1:0] hot_buttons [4];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_records();
    int i;
    int j;
    for (i = 0; i < NumButtons; i++) begin
      main_vld[i]  = 1'b0;
      main_code[i] = '0;
      sub_held[i]  = 0;
      click_vld[i] = 1'b0;
      click_mb[i]  = '0;
      latch_vld[i] = 1'b0;
      latch_mb[i]  = '0;
      for (j = 0; j < MaxSubs; j++) sub_codes[i][j] = '0;
    end
  endfunction

  function automatic void add_event(input logic [KindW-1:0] kind, input logic [KeyW-1:0] key,
                                    input logic [MouseW-1:0] mouse,
                                    input logic signed [StepW-1:0] wheel,
                                    input logic [BtnW-1:0] nbtn, input logic latch);
    inject_ev_t r;
    r.kind  = kind;
    r.key   = key;
    r.mouse = mouse;
    r.wheel = wheel;
    r.nbtn  = nbtn;
    r.latch = latch;
    r.last  = 1'b0;
    expected_events.push_back(r);
  endfunction

  // Work out the events of one accepted transaction and update the records
  function automatic int unsigned predict_events(input btn_event_t e);
    int unsigned b;
    int unsigned lim;
    int unsigned cnt;
    int unsigned n0;
    int i;
    inject_ev_t tail;
    n0 = expected_events.size();
    b  = e.btn;
    if (e.cmd == CMD_RELEASE_ALL) begin
      // one release-all, then a cleared notice per latched button
      add_event(EV_RELEASE_ALL, '0, '0, '0, '0, 1'b0);
      for (i = 0; i < NumButtons; i++) begin
        if (latch_vld[i]) add_event(EV_NOTICE, '0, latch_mb[i], '0, BtnW'(i), 1'b0);
      end
      clear_records();
    end else if (b < NumButtons) begin
      if (!e.pressed) begin
        // free sub keys newest first, then main key, then click; latch stays
        for (i = int'(sub_held[b]) - 1; i >= 0; i--) begin
          add_event(EV_KEY_UP, sub_codes[b][i], '0, '0, '0, 1'b0);
        end
        sub_held[b] = 0;
        if (main_vld[b]) begin
          add_event(EV_KEY_UP, main_code[b], '0, '0, '0, 1'b0);
          main_vld[b] = 1'b0;
        end
        if (click_vld[b]) begin
          add_event(EV_MOUSE_UP, '0, click_mb[b], '0, '0, 1'b0);
          click_vld[b] = 1'b0;
        end
      end else begin
        case (e.cmd)
          CMD_KEY: begin
            if (!main_vld[b]) begin
              lim = e.sub_cnt;
              if (lim > MaxSubs) lim = MaxSubs;
              if (lim > SubFields) lim = SubFields;
              cnt = 0;
              add_event(EV_KEY_DOWN, e.main_key, '0, '0, '0, 1'b0);
              for (i = 0; i < int'(lim); i++) begin
                if (e.subs[i] != e.main_key) begin
                  add_event(EV_KEY_DOWN, e.subs[i], '0, '0, '0, 1'b0);
                  sub_codes[b][cnt] = e.subs[i];
                  cnt++;
                end
              end
              main_vld[b]  = 1'b1;
              main_code[b] = e.main_key;
              sub_held[b]  = cnt;
            end
          end
          CMD_CLICK: begin
            if (!click_vld[b]) begin
              add_event(EV_MOUSE_DOWN, '0, e.mouse, '0, '0, 1'b0);
              click_vld[b] = 1'b1;
              click_mb[b]  = e.mouse;
            end
          end
          CMD_TOGGLE: begin
            if (latch_vld[b]) begin
              add_event(EV_MOUSE_UP, '0, e.mouse, '0, '0, 1'b0);
              add_event(EV_NOTICE, '0, e.mouse, '0, e.btn, 1'b0);
              latch_vld[b] = 1'b0;
            end else begin
              add_event(EV_MOUSE_DOWN, '0, e.mouse, '0, '0, 1'b0);
              add_event(EV_NOTICE, '0, e.mouse, '0, e.btn, 1'b1);
              latch_vld[b] = 1'b1;
              latch_mb[b]  = e.mouse;
            end
          end
          CMD_WHEEL_UP:   add_event(EV_WHEEL, '0, '0, WheelUp, '0, 1'b0);
          CMD_WHEEL_DOWN: add_event(EV_WHEEL, '0, '0, WheelDown, '0, 1'b0);
          default: ;
        endcase
      end
    end
    // mark the final event of the transaction
    if (expected_events.size() > n0) begin
      tail = expected_events.pop_back();
      tail.last = 1'b1;
      expected_events.push_back(tail);
    end
    return expected_events.size() - n0;
  endfunction

  function automatic btn_event_t make_event(input logic [CmdW-1:0] c, input logic [BtnW-1:0] b,
                                            input logic p, input logic [KeyW-1:0] mk,
                                            input logic [MouseW-1:0] mb,
                                            input logic [CntW-1:0] sc,
                                            input logic [KeyW-1:0] s0, input logic [KeyW-1:0] s1,
                                            input logic [KeyW-1:0] s2, input logic [KeyW-1:0] s3);
    btn_event_t e;
    e.cmd      = c;
    e.btn      = b;
    e.pressed  = p;
    e.main_key = mk;
    e.mouse    = mb;
    e.sub_cnt  = sc;
    e.subs[0]  = s0;
    e.subs[1]  = s1;
    e.subs[2]  = s2;
    e.subs[3]  = s3;
    return e;
  endfunction

  function automatic logic [BtnW-1:0] pick_button();
    if ($urandom_range(0, 3) != 0) return hot_buttons[$urandom_range(0, 3)];
    return BtnW'($urandom_range(0, NumButtons - 1));
  endfunction

  // Random transaction; commands weighted toward the ones that build up records
  function automatic btn_event_t random_event();
    btn_event_t e;
    int unsigned w;
    int i;
    w = $urandom_range(0, 99);
    if (w < 35)      e.cmd = CMD_KEY;
    else if (w < 52) e.cmd = CMD_CLICK;
    else if (w < 68) e.cmd = CMD_TOGGLE;
    else if (w < 78) e.cmd = CMD_WHEEL_UP;
    else if (w < 88) e.cmd = CMD_WHEEL_DOWN;
    else if (w < 93) e.cmd = CMD_NOP;
    else if (w < 96) e.cmd = CmdUnused;
    else             e.cmd = CMD_RELEASE_ALL;
    e.btn      = pick_button();
    e.pressed  = ($urandom_range(0, 99) < 55);
    e.main_key = KeyW'($urandom_range(0, 255));
    e.mouse    = MouseW'($urandom_range(0, 7));
    e.sub_cnt  = ($urandom_range(0, 3) == 0) ? CntW'($urandom_range(0, 7))
                                             : CntW'($urandom_range(0, 4));
    for (i = 0; i < SubFields; i++) begin
      e.subs[i] = ($urandom_range(0, 3) == 0) ? e.main_key : KeyW'($urandom_range(0, 255));
    end
    return e;
  endfunction

  // Send one transaction, idling between bursts when gaps are on
  task automatic send_event(input btn_event_t e);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_valid     <= 1'b1;
    cmd          <= e.cmd;
    button       <= e.btn;
    pressed      <= e.pressed;
    main_key     <= e.main_key;
    mouse_button <= e.mouse;
    sub_count    <= e.sub_cnt;
    sub_key_0    <= e.subs[0];
    sub_key_1    <= e.subs[1];
    sub_key_2    <= e.subs[2];
    sub_key_3    <= e.subs[3];
    do @(posedge clk_i); while (in_stall);
    void'(predict_events(e));
    sent_items++;
  endtask

  // Hold off the sender until every expected event has come, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic test_key_combos();
    // sub keys equal to the main key drop out; sub count above four is clipped
    send_event(make_event(CMD_KEY, 5'd0, 1'b1, 8'h00, 3'd0, 3'd7, 8'h00, 8'hFF, 8'h01, 8'h00));
    send_event(make_event(CMD_KEY, 5'd0, 1'b1, 8'h33, 3'd0, 3'd1, 8'h44, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_KEY, 5'd31, 1'b1, 8'hFF, 3'd7, 3'd4, 8'h12, 8'h34, 8'h56, 8'h78));
    // release ignores the command
    send_event(make_event(CMD_CLICK, 5'd31, 1'b0, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_KEY, 5'd0, 1'b0, 8'hFF, 3'd7, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_event(make_event(CMD_KEY, 5'd0, 1'b0, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_KEY, 5'd5, 1'b1, 8'hA5, 3'd0, 3'd0, 8'hA5, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_NOP, 5'd5, 1'b0, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  task automatic test_click_hold();
    send_event(make_event(CMD_CLICK, 5'd1, 1'b1, 8'h00, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_CLICK, 5'd1, 1'b1, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_KEY, 5'd1, 1'b1, 8'h5A, 3'd0, 3'd2, 8'h11, 8'h22, 8'h00, 8'h00));
    send_event(make_event(CMD_TOGGLE, 5'd1, 1'b0, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  task automatic test_toggle_latch();
    send_event(make_event(CMD_TOGGLE, 5'd2, 1'b1, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    // latch survives the release
    send_event(make_event(CMD_TOGGLE, 5'd2, 1'b0, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    // toggle off reports the mouse button of this transaction
    send_event(make_event(CMD_TOGGLE, 5'd2, 1'b1, 8'h00, 3'd5, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_TOGGLE, 5'd31, 1'b1, 8'h00, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_TOGGLE, 5'd0, 1'b1, 8'h00, 3'd3, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  task automatic test_wheel_and_idle_codes();
    send_event(make_event(CMD_WHEEL_UP, 5'd3, 1'b1, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_WHEEL_DOWN, 5'd3, 1'b1, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_NOP, 5'd3, 1'b1, 8'hFF, 3'd7, 3'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_event(make_event(CmdUnused, 5'd3, 1'b1, 8'hFF, 3'd7, 3'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_event(make_event(CMD_WHEEL_UP, 5'd3, 1'b0, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  task automatic test_release_all();
    send_event(make_event(CMD_CLICK, 5'd4, 1'b1, 8'h00, 3'd2, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    // acts even with pressed low; notices for buttons 0 and 31 in order
    send_event(make_event(CMD_RELEASE_ALL, 5'd9, 1'b0, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_KEY, 5'd4, 1'b0, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_event(make_event(CMD_RELEASE_ALL, 5'd31, 1'b1, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  // A few presses on one button, then its release
  task automatic run_session();
    logic [BtnW-1:0] b;
    btn_event_t e;
    int unsigned k;
    int unsigned steps;
    b = pick_button();
    steps = $urandom_range(1, 3);
    for (k = 0; k < steps; k++) begin
      e = random_event();
      e.btn = b;
      e.pressed = 1'b1;
      if (e.cmd == CMD_RELEASE_ALL || e.cmd == CMD_NOP || e.cmd == CmdUnused) e.cmd = CMD_KEY;
      send_event(e);
    end
    e = random_event();
    e.btn = b;
    e.pressed = 1'b0;
    if (e.cmd == CMD_RELEASE_ALL) e.cmd = CMD_WHEEL_UP;
    send_event(e);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned since_pause;
    int i;
    goal = sent_items + RandomItems;
    since_pause = 0;
    while (sent_items < goal) begin
      if ($urandom_range(0, 9) < 7) run_session();
      else send_event(random_event());
      since_pause++;
      // pause until drained, then reshuffle buttons and sender pacing
      if (since_pause >= 40) begin
        wait_drained();
        for (i = 0; i < 4; i++) hot_buttons[i] = BtnW'($urandom_range(0, NumButtons - 1));
        gaps_on = ($urandom_range(0, 3) != 0);
        since_pause = 0;
      end
    end
    wait_drained();
  endtask

  // Receiver stall pattern: free, light random, periodic or heavy, with capped runs
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned stall_run;
  int unsigned cyc;
  logic        stall_next;

  always @(posedge clk_i) begin
    cyc++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(40, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       stall_next = 1'b0;
      1:       stall_next = ($urandom_range(0, 3) == 0);
      2:       stall_next = ((cyc % 5) < 2);
      default: stall_next = ($urandom_range(0, 3) != 0);
    endcase
    if (stall_next && stall_run >= 16) stall_next = 1'b0;
    stall_run = stall_next ? stall_run + 1 : 0;
    out_stall <= stall_next;
  end

  // Check each output transaction against the oldest expected event
  inject_ev_t got_ev;
  inject_ev_t want_ev;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      got_ev.kind  = event_kind;
      got_ev.key   = key_code;
      got_ev.mouse = mouse_code;
      got_ev.wheel = wheel_step;
      got_ev.nbtn  = notice_button;
      got_ev.latch = latch_on;
      got_ev.last  = last_flag;
      if (expected_events.size() == 0) begin
        if (error_count < ErrorReportMax)
          $display("%0t: unexpected event kind=%0d key=%0h mouse=%0d wheel=%0d btn=%0d latch=%0b last=%0b",
                   $realtime, got_ev.kind, got_ev.key, got_ev.mouse, got_ev.wheel, got_ev.nbtn,
                   got_ev.latch, got_ev.last);
        error_count++;
      end else begin
        want_ev = expected_events.pop_front();
        if (got_ev.kind !== want_ev.kind || got_ev.key !== want_ev.key ||
            got_ev.mouse !== want_ev.mouse || got_ev.wheel !== want_ev.wheel ||
            got_ev.nbtn !== want_ev.nbtn || got_ev.latch !== want_ev.latch ||
            got_ev.last !== want_ev.last) begin
          if (error_count < ErrorReportMax) begin
            $display("%0t: mismatch expected kind=%0d key=%0h mouse=%0d wheel=%0d btn=%0d latch=%0b last=%0b",
                     $realtime, want_ev.kind, want_ev.key, want_ev.mouse, want_ev.wheel,
                     want_ev.nbtn, want_ev.latch, want_ev.last);
            $display("%0t:          actual   kind=%0d key=%0h mouse=%0d wheel=%0d btn=%0d latch=%0b last=%0b",
                     $realtime, got_ev.kind, got_ev.key, got_ev.mouse, got_ev.wheel,
                     got_ev.nbtn, got_ev.latch, got_ev.last);
          end
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transaction
  int unsigned idle_cycles;

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  // Main sequence
  initial begin
    stall_mode  = 0;
    mode_left   = 0;
    stall_run   = 0;
    cyc         = 0;
    error_count = 0;
    sent_items  = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    for (int i = 0; i < 4; i++) hot_buttons[i] = BtnW'($urandom_range(0, NumButtons - 1));
    clear_records();
    rst_ni       <= 1'b0;
    in_valid     <= 1'b0;
    out_stall    <= 1'b0;
    cmd          <= CMD_NOP;
    button       <= '0;
    pressed      <= 1'b0;
    main_key     <= '0;
    mouse_button <= '0;
    sub_count    <= '0;
    sub_key_0    <= '0;
    sub_key_1    <= '0;
    sub_key_2    <= '0;
    sub_key_3    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_key_combos();
    test_click_hold();
    test_toggle_latch();
    test_wheel_and_idle_codes();
    test_release_all();
    test_random_traffic();

    wait_drained();
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
